>>> design/tsched_pkg.sv
// ----------------------------------------------------------------------------
// tsched_pkg - shared types and constants of the rotating task scheduler
// Queue geometry, task word width, event codes, level codes and the packed
// layouts of the input word and the result word.
// ----------------------------------------------------------------------------
package tsched_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TASK_BITS   = 16;
    localparam int NUM_LEVELS  = 3;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W      = 16;
    localparam int LVL_W     = 2;
    localparam int QUANTUM_W = 8;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(10);

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    typedef logic [TASK_BITS-1:0] task_t;
    typedef logic [PTR_W-1:0]     ptr_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [LVL_W-1:0]     lvl_t;

    typedef enum logic [1:0] {
        MODE_SUBMIT = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_FINISH = 2'd2
    } mode_t;

    localparam lvl_t LVL_HIGH    = 2'd0;
    localparam lvl_t LVL_MEDIUM  = 2'd1;
    localparam lvl_t LVL_LOW     = 2'd2;
    localparam lvl_t LVL_INVALID = 2'd3;

    // last field in the lowest bits
    typedef struct packed {
        lvl_t            level;
        logic [ID_W-1:0] task_id;
        logic [1:0]      mode;
    } item_t;

    typedef struct packed {
        logic            overflow;
        logic            busy_res;
        lvl_t            preempt_level;
        logic [ID_W-1:0] preempt_task;
        logic            preempt_valid;
        lvl_t            dispatch_level;
        logic [ID_W-1:0] dispatch_task;
        logic            dispatch_valid;
    } res_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctl_t;

    typedef struct packed {
        logic  not_empty;
        logic  full;
        task_t head;
    } fifo_sts_t;

endpackage

>>> design/tsched_fifo.sv
// ----------------------------------------------------------------------------
// tsched_fifo - one task queue of the scheduler
// Circular buffer with head, tail and fill count. The head word is kept in
// a register that is read ahead from the next head address, with the word
// being written forwarded when the addresses meet.
// ----------------------------------------------------------------------------
module tsched_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tsched_pkg::fifo_ctl_t ctl,
    input  tsched_pkg::task_t     push_data,
    output tsched_pkg::fifo_sts_t sts
);
    import tsched_pkg::*;

    task_t mem [QUEUE_DEPTH];
    task_t head_data_reg;

    ptr_t head_ptr_reg, head_ptr_next;
    ptr_t tail_ptr_reg, tail_ptr_next;
    cnt_t cnt_reg, cnt_next;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        head_ptr_next = ctl.pop  ? ptr_inc(head_ptr_reg) : head_ptr_reg;
        tail_ptr_next = ctl.push ? ptr_inc(tail_ptr_reg) : tail_ptr_reg;
        cnt_next      = cnt_reg + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg <= '0;
            tail_ptr_reg <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            head_ptr_reg <= head_ptr_next;
            tail_ptr_reg <= tail_ptr_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_ptr_reg] <= push_data;
        end
    end

    // read ahead: hold the word at the next head address
    always_ff @(posedge clk)
    begin
        if (ctl.push && (tail_ptr_reg == head_ptr_next))
        begin
            head_data_reg <= push_data;
        end
        else
        begin
            head_data_reg <= mem[head_ptr_next];
        end
    end

    assign sts.not_empty = (cnt_reg != '0);
    assign sts.full      = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign sts.head      = head_data_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == CNT_W'(QUEUE_DEPTH)) |-> (head_ptr_reg == tail_ptr_reg))
        else $error("queue pointers disagree with fill count");

endmodule

>>> design/tsched_ctrl.sv
// ----------------------------------------------------------------------------
// tsched_ctrl - event decode, quantum timer and dispatch pick
// Applies one event word to the running-task state, steers the single push
// of the event to its queue and pops the head of the highest non-empty
// queue when no task is left running.
// ----------------------------------------------------------------------------
module tsched_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tsched_pkg::QUANTUM_W-1:0] cfg_wdata,
    input  logic                           go,
    input  tsched_pkg::item_t              item,
    input  tsched_pkg::fifo_sts_t          sts [tsched_pkg::NUM_LEVELS],
    output tsched_pkg::fifo_ctl_t          ctl [tsched_pkg::NUM_LEVELS],
    output tsched_pkg::task_t              push_data,
    output tsched_pkg::res_t               res
);
    import tsched_pkg::*;

    logic                 running_reg, running_next;
    task_t                cur_task_reg, cur_task_next;
    lvl_t                 cur_level_reg, cur_level_next;
    logic [QUANTUM_W-1:0] ticks_reg, ticks_next;
    logic [QUANTUM_W-1:0] quantum_reg;

    logic  push_en;
    lvl_t  push_lv;
    lvl_t  lv_eff;
    lvl_t  rot_lv;
    logic  running_ev;
    logic  found;
    logic  push_ok [NUM_LEVELS];
    logic  avail   [NUM_LEVELS];
    task_t pick_task;
    lvl_t  pick_lv;

    always_comb
    begin
        lv_eff = (item.level == LVL_INVALID) ? LVL_LOW : item.level;
        rot_lv = (cur_level_reg == LVL_LOW) ? LVL_HIGH : cur_level_reg + 1'b1;

        push_en    = 1'b0;
        push_lv    = lv_eff;
        push_data  = task_t'(item.task_id);
        running_ev = running_reg;
        ticks_next = ticks_reg;
        res        = '0;

        unique case (mode_t'(item.mode))
            MODE_SUBMIT:
            begin
                push_en = 1'b1;
            end
            MODE_TICK:
            begin
                if (running_reg)
                begin
                    if (ticks_reg <= QUANTUM_W'(1))
                    begin
                        // quantum spent: stop and rotate to the next level
                        running_ev        = 1'b0;
                        ticks_next        = '0;
                        res.preempt_valid = 1'b1;
                        res.preempt_task  = ID_W'(cur_task_reg);
                        res.preempt_level = rot_lv;
                        push_en           = 1'b1;
                        push_lv           = rot_lv;
                        push_data         = cur_task_reg;
                    end
                    else
                    begin
                        ticks_next = ticks_reg - 1'b1;
                    end
                end
            end
            MODE_FINISH:
            begin
                if (running_reg)
                begin
                    running_ev = 1'b0;
                    ticks_next = '0;
                end
            end
            default:
            begin
            end
        endcase

        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            push_ok[i] = push_en && (push_lv == LVL_W'(i)) && !sts[i].full;
            avail[i]   = sts[i].not_empty || push_ok[i];
        end

        res.overflow = 1'b0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (push_en && (push_lv == LVL_W'(i)) && sts[i].full)
            begin
                res.overflow = 1'b1;
            end
        end

        // highest non-empty queue wins; an empty queue hands over the word
        // being pushed into it
        found     = 1'b0;
        pick_task = '0;
        pick_lv   = LVL_HIGH;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (!found && avail[i])
            begin
                found     = 1'b1;
                pick_lv   = LVL_W'(i);
                pick_task = sts[i].not_empty ? sts[i].head : push_data;
            end
        end

        running_next   = running_ev;
        cur_task_next  = cur_task_reg;
        cur_level_next = cur_level_reg;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            ctl[i].push = go && push_ok[i];
            ctl[i].pop  = 1'b0;
        end

        if (!running_ev && found)
        begin
            running_next       = 1'b1;
            cur_task_next      = pick_task;
            cur_level_next     = pick_lv;
            ticks_next         = quantum_reg;
            res.dispatch_valid = 1'b1;
            res.dispatch_task  = ID_W'(pick_task);
            res.dispatch_level = pick_lv;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                ctl[i].pop = go && (pick_lv == LVL_W'(i));
            end
        end

        res.busy_res = running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            cur_task_reg  <= '0;
            cur_level_reg <= LVL_HIGH;
            ticks_reg     <= '0;
        end
        else if (go)
        begin
            running_reg   <= running_next;
            cur_task_reg  <= cur_task_next;
            cur_level_reg <= cur_level_next;
            ticks_reg     <= ticks_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
        end
        else if (cfg_we)
        begin
            quantum_reg <= cfg_wdata;
        end
    end

    a_idle_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (ticks_reg == '0))
        else $error("quantum counter live while no task runs");

    a_dispatch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (go && res.dispatch_valid) |=> running_reg)
        else $error("dispatch did not leave a task running");

    a_preempt_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (go && res.preempt_valid) |-> (item.mode == MODE_TICK && running_reg))
        else $error("preemption without a tick on a running task");

endmodule

>>> design/three_level_rotating_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// three_level_rotating_task_scheduler_core - three-queue rotating scheduler
// Input register, single-pass event logic over three task queues, result
// register.
// ----------------------------------------------------------------------------
// Each input word is one event (submit a task to a level, a time tick, or
// finish of the running task) and yields exactly one result word. The block
// takes one word per clock unless the output stalls. The word is registered,
// the whole event (queue push, quantum count, preemption and the pick of the
// highest non-empty queue) is worked out in one pass, and the result is
// registered. The input stalls only while a result word waits on the output.
// The queue head words are read ahead into registers so the pick needs no
// memory access in that pass. The quantum register may be written only while
// no event is in flight.
module three_level_rotating_task_scheduler_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tsched_pkg::QUANTUM_W-1:0]   cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // mode[1:0], task_id[17:2], level[19:18], zero pad[23:20]
    input  logic [tsched_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // dispatch_valid[0], dispatch_task[16:1], dispatch_level[18:17],
    // preempt_valid[19], preempt_task[35:20], preempt_level[37:36],
    // busy_res[38], overflow[39]
    output logic [tsched_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tsched_pkg::*;

    logic  in_valid_reg, in_valid_next;
    item_t in_item_reg;
    logic  out_valid_reg, out_valid_next;
    res_t  out_res_reg;

    logic      advance;
    logic      take;
    res_t      res;
    task_t     push_data;
    fifo_ctl_t ctl [NUM_LEVELS];
    fifo_sts_t sts [NUM_LEVELS];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    tsched_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .go        (advance),
        .item      (in_item_reg),
        .sts       (sts),
        .ctl       (ctl),
        .push_data (push_data),
        .res       (res)
    );

    for (genvar g = 0; g < NUM_LEVELS; g++)
    begin : g_queue
        tsched_fifo u_fifo (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl[g]),
            .push_data (push_data),
            .sts       (sts[g])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_res_reg);

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - regression for the three-level rotating task scheduler core
// Drives submit, tick and finish words over the input stream. A scheduler
// model inside the bench keeps its own queues and quantum counter and
// predicts every result word. The monitor compares each result field by
// field, in order. Both stream sides idle at random, one long output
// hold-off fills the block, and the quantum is swept across its range.
// ----------------------------------------------------------------------------
module tb_top;
    import tsched_pkg::*;

    localparam logic [1:0] MODE_NOP = 2'd3;

    localparam int BIAS_BALANCED = 0;
    localparam int BIAS_FILL     = 1;
    localparam int BIAS_DRAIN    = 2;

    localparam int PHASES          = 7;
    localparam int PHASE_WORDS     = 190;
    localparam int CHUNK_WORDS     = 38;
    localparam int HOLD_CYCLES     = 80;
    localparam int SETTLE_CYCLES   = 6;
    localparam int MAX_PRINTED     = 40;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [QUANTUM_W-1:0]   cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // scheduler model state
    task_t          q_store [NUM_LEVELS][QUEUE_DEPTH];
    int             q_head [NUM_LEVELS];
    int             q_tail [NUM_LEVELS];
    int             q_fill [NUM_LEVELS];
    bit             running;
    task_t          cur_task;
    lvl_t           cur_lvl;
    logic [7:0]     ticks_left;
    logic [7:0]     quantum;

    res_t predicted_results [$];

    int  errors         = 0;
    int  checked_count  = 0;
    int  words_sent     = 0;
    int  dispatch_count = 0;
    int  preempt_count  = 0;
    int  overflow_count = 0;
    int  quantum_writes = 0;
    bit  quiet          = 1'b0;
    bit  hold_req       = 1'b0;

    three_level_rotating_task_scheduler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_PRINTED)
        begin
            $display("MISMATCH result %0d: %s", checked_count, msg);
        end
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    function automatic bit queue_push(int lv, task_t t);
        if (q_fill[lv] >= QUEUE_DEPTH)
        begin
            return 1'b0;
        end
        q_store[lv][q_tail[lv]] = t;
        q_tail[lv] = (q_tail[lv] + 1) % QUEUE_DEPTH;
        q_fill[lv]++;
        return 1'b1;
    endfunction

    // Work out the result word that one accepted event produces.
    function automatic res_t schedule_event(item_t it);
        res_t r;
        int   lv;
        int   i;
        lvl_t nl;
        r  = '0;
        lv = (it.level == LVL_INVALID) ? int'(LVL_LOW) : int'(it.level);
        case (it.mode)
            MODE_SUBMIT:
            begin
                if (!queue_push(lv, it.task_id))
                begin
                    r.overflow = 1'b1;
                end
            end
            MODE_TICK:
            begin
                if (running)
                begin
                    if (ticks_left <= 8'd1)
                    begin
                        // rotate: high to medium, medium to low, low wraps to high
                        nl = (cur_lvl == LVL_LOW) ? LVL_HIGH : lvl_t'(cur_lvl + 1'b1);
                        running         = 1'b0;
                        ticks_left      = '0;
                        r.preempt_valid = 1'b1;
                        r.preempt_task  = cur_task;
                        r.preempt_level = nl;
                        if (!queue_push(int'(nl), cur_task))
                        begin
                            r.overflow = 1'b1;
                        end
                    end
                    else
                    begin
                        ticks_left = ticks_left - 1'b1;
                    end
                end
            end
            MODE_FINISH:
            begin
                running    = 1'b0;
                ticks_left = '0;
            end
            default:
            begin
            end
        endcase
        for (i = 0; i < NUM_LEVELS && !running; i++)
        begin
            if (q_fill[i] != 0)
            begin
                cur_task         = q_store[i][q_head[i]];
                q_head[i]        = (q_head[i] + 1) % QUEUE_DEPTH;
                q_fill[i]--;
                cur_lvl          = lvl_t'(i);
                ticks_left       = quantum;
                running          = 1'b1;
                r.dispatch_valid = 1'b1;
                r.dispatch_task  = cur_task;
                r.dispatch_level = cur_lvl;
            end
        end
        r.busy_res = running;
        dispatch_count += r.dispatch_valid;
        preempt_count  += r.preempt_valid;
        overflow_count += r.overflow;
        return r;
    endfunction

    function automatic item_t make_word(logic [1:0] mode, logic [ID_W-1:0] id, lvl_t lv);
        item_t it;
        it.mode    = mode;
        it.task_id = id;
        it.level   = lv;
        return it;
    endfunction

    function automatic item_t random_word(int bias);
        int         pick;
        int         submit_lim;
        int         tick_lim;
        int         finish_lim;
        logic [1:0] mode;
        pick = $urandom_range(0, 99);
        case (bias)
            BIAS_FILL:
            begin
                submit_lim = 70;
                tick_lim   = 90;
                finish_lim = 97;
            end
            BIAS_DRAIN:
            begin
                submit_lim = 25;
                tick_lim   = 55;
                finish_lim = 95;
            end
            default:
            begin
                submit_lim = 40;
                tick_lim   = 80;
                finish_lim = 96;
            end
        endcase
        if (pick < submit_lim)
            mode = MODE_SUBMIT;
        else if (pick < tick_lim)
            mode = MODE_TICK;
        else if (pick < finish_lim)
            mode = MODE_FINISH;
        else
            mode = MODE_NOP;
        return make_word(mode, ID_W'($urandom_range(0, 65535)), lvl_t'($urandom_range(0, 3)));
    endfunction

    // Offer one word, hold it until taken, then record its expected result.
    task automatic send_event(item_t it);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(it);
        do
            @(posedge clk);
        while (!s_tready);
        predicted_results.push_back(schedule_event(it));
        words_sent++;
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_quantum(logic [7:0] q);
        drain_and_settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= q;
        @(posedge clk);
        cfg_we    <= 1'b0;
        quantum = q;
        quantum_writes++;
    endtask

    // Idle events are ignored, then one task runs out the reset quantum.
    task automatic test_reset_quantum();
        send_event(make_word(MODE_FINISH, 16'h0000, LVL_HIGH));
        send_event(make_word(MODE_TICK, 16'hFFFF, LVL_INVALID));
        send_event(make_word(MODE_NOP, 16'h0000, LVL_HIGH));
        send_event(make_word(MODE_SUBMIT, 16'hFFFF, LVL_HIGH));
        repeat (int'(QUANTUM_RESET)) send_event(make_word(MODE_TICK, 16'h0000, LVL_HIGH));
        send_event(make_word(MODE_FINISH, 16'hFFFF, LVL_LOW));
    endtask

    // Fill the medium queue, overflow it on submit and again on preemption.
    task automatic test_full_queue();
        int i;
        set_quantum(8'd1);
        send_event(make_word(MODE_SUBMIT, 16'hA5A5, LVL_HIGH));
        for (i = 0; i <= QUEUE_DEPTH; i++)
        begin
            send_event(make_word(MODE_SUBMIT, ID_W'(16'hF000 | i), LVL_MEDIUM));
        end
        send_event(make_word(MODE_TICK, 16'h0000, LVL_HIGH));
    endtask

    // Hold the output for a long stretch while words keep coming.
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (40) send_event(random_word(BIAS_FILL));
    endtask

    task automatic test_random_phases();
        int phase_q [PHASES];
        int p;
        int n;
        int bias;
        phase_q = '{255, 0, 2, 1, 3, 200, 10};
        phase_q[4] = $urandom_range(3, 40);
        phase_q[5] = $urandom_range(41, 254);
        for (p = 0; p < PHASES; p++)
        begin
            set_quantum(8'(phase_q[p]));
            if (p == PHASES - 1)
            begin
                quiet = 1'b1;
            end
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if (n % CHUNK_WORDS == 0)
                begin
                    bias = $urandom_range(BIAS_BALANCED, BIAS_DRAIN);
                end
                send_event(random_word(bias));
            end
        end
    endtask

    // result monitor and output-side flow control
    initial
    begin : result_sink
        int   stall_left;
        res_t got;
        res_t want;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = res_t'(m_tdata);
                if (predicted_results.size() == 0)
                begin
                    report_mismatch("result word with nothing expected");
                end
                else
                begin
                    want = predicted_results.pop_front();
                    compare_field("dispatch_valid", got.dispatch_valid, want.dispatch_valid);
                    compare_field("dispatch_task", got.dispatch_task, want.dispatch_task);
                    compare_field("dispatch_level", got.dispatch_level, want.dispatch_level);
                    compare_field("preempt_valid", got.preempt_valid, want.preempt_valid);
                    compare_field("preempt_task", got.preempt_task, want.preempt_task);
                    compare_field("preempt_level", got.preempt_level, want.preempt_level);
                    compare_field("busy_res", got.busy_res, want.busy_res);
                    compare_field("overflow", got.overflow, want.overflow);
                end
                checked_count++;
            end
            if (hold_req)
            begin
                stall_left = HOLD_CYCLES;
                hold_req   = 1'b0;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #400000;
        $display("timeout with %0d results outstanding", predicted_results.size());
        $display("three_level_rotating_task_scheduler_core regression: fail");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        foreach (q_fill[i])
        begin
            q_head[i] = 0;
            q_tail[i] = 0;
            q_fill[i] = 0;
        end
        running    = 1'b0;
        cur_task   = '0;
        cur_lvl    = LVL_HIGH;
        ticks_left = '0;
        quantum    = QUANTUM_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_quantum();
        test_full_queue();
        test_backpressure();
        test_random_phases();

        drain_and_settle();
        if (predicted_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      predicted_results.size()));
        end
        $display("Covered %0d words and %0d results over %0d quantum settings.",
                 words_sent, checked_count, quantum_writes + 1);
        $display("Model saw %0d dispatches, %0d preemptions, %0d dropped tasks; %0d mismatches.",
                 dispatch_count, preempt_count, overflow_count, errors);
        if (errors == 0)
        begin
            $display("three_level_rotating_task_scheduler_core regression: pass");
        end
        else
        begin
            $display("three_level_rotating_task_scheduler_core regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/tsched_pkg.sv
design/tsched_fifo.sv
design/tsched_ctrl.sv
design/three_level_rotating_task_scheduler_core.sv
test/tb_top.sv
